### design/lzd_pkg.sv
// Shared types and constants of the LZSS window decoder.
`default_nettype none
package lzd_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_AW      = $clog2(WINDOW_SIZE);
    localparam logic [WIN_AW-1:0] START_POS = WIN_AW'(12'hFEE);
    localparam logic [7:0] FILL_BYTE = 8'h20;

    localparam int LEN_W      = 4;
    localparam int MIN_LEN    = 3;
    localparam int LEFT_W     = 5;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
    localparam int OFIFO_CW    = $clog2(OFIFO_DEPTH + 1);

    typedef struct packed {
        logic              lit;
        logic [WIN_AW-1:0] addr;
        logic [LEN_W-1:0]  len;
    } t_cmd;

endpackage
`default_nettype wire

### design/lzd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lzd_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096,
    localparam int AddrW = $clog2(Depth)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AddrW-1:0] i_waddr,
    input  wire logic [Width-1:0] i_wdata,
    input  wire logic [AddrW-1:0] i_raddr,
    output logic      [Width-1:0] o_rdata
);

    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### design/lzd_front.sv
// Stream parser: splits flag, literal and reference bytes into commands.
`default_nettype none
module lzd_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_hold,
    output logic             o_cmd_push,
    output lzd_pkg::t_cmd    o_cmd
);
    import lzd_pkg::*;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_DATA,
        PH_REF2
    } t_phase;

    t_phase      r_phase;
    logic [7:0]  r_flag_bits;
    logic [3:0]  r_flags_left;
    logic [7:0]  r_held_low;

    logic        accept;
    logic [3:0]  flags_next;

    assign accept     = i_push && !i_hold;
    assign flags_next = (r_flags_left != 4'd0) ? r_flags_left - 4'd1 : 4'd0;

    always_comb begin
        o_cmd_push = 1'b0;
        o_cmd.lit  = 1'b1;
        o_cmd.addr = WIN_AW'(i_byte);
        o_cmd.len  = '0;
        if (accept) begin
            unique case (r_phase)
                PH_DATA: begin
                    o_cmd_push = r_flag_bits[0];
                end
                PH_REF2: begin
                    o_cmd_push = 1'b1;
                    o_cmd.lit  = 1'b0;
                    o_cmd.addr = {i_byte[7:4], r_held_low};
                    o_cmd.len  = i_byte[3:0];
                end
                default: begin
                    o_cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FLAG;
            r_flag_bits  <= '0;
            r_flags_left <= '0;
            r_held_low   <= '0;
        end else if (accept) begin
            unique case (r_phase)
                PH_DATA: begin
                    if (r_flag_bits[0]) begin
                        r_flag_bits  <= r_flag_bits >> 1;
                        r_flags_left <= flags_next;
                        r_phase      <= (flags_next == 4'd0) ? PH_FLAG : PH_DATA;
                    end else begin
                        r_held_low <= i_byte;
                        r_phase    <= PH_REF2;
                    end
                end
                PH_REF2: begin
                    r_flag_bits  <= r_flag_bits >> 1;
                    r_flags_left <= flags_next;
                    r_phase      <= (flags_next == 4'd0) ? PH_FLAG : PH_DATA;
                end
                default: begin
                    r_flag_bits  <= i_byte;
                    r_flags_left <= 4'd8;
                    r_phase      <= PH_DATA;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

### design/lzd_cmdq.sv
// Short command queue between the parser and the copy engine.
`default_nettype none
module lzd_cmdq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  lzd_pkg::t_cmd    i_cmd,
    output logic             o_full,
    input  wire logic        i_pop,
    output lzd_pkg::t_cmd    o_cmd,
    output logic             o_empty
);
    import lzd_pkg::*;

    t_cmd                r_slot [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  r_wp;
    logic [CMDQ_AW-1:0]  r_rp;
    logic [CMDQ_CW-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == CMDQ_CW'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + CMDQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + CMDQ_AW'(1);
            end
            r_cnt <= r_cnt + CMDQ_CW'(do_push) - CMDQ_CW'(do_pop);
        end
    end

endmodule
`default_nettype wire

### design/lzd_back.sv
// Copy engine: window memory, clearing pass, byte emission and output queue.
`default_nettype none
module lzd_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  lzd_pkg::t_cmd    i_cmd,
    input  wire logic        i_cmd_empty,
    output logic             o_cmd_pop,
    output logic             o_clearing,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_run,
    output logic             o_empty,
    input  wire logic        i_pop
);
    import lzd_pkg::*;

    logic                 r_clr_busy;
    logic [WIN_AW-1:0]    r_clr_addr;

    logic                 r_busy;
    logic                 r_lit;
    logic [WIN_AW-1:0]    r_addr;
    logic [LEFT_W-1:0]    r_left;

    logic                 r_s2_valid;
    logic                 r_s2_lit;
    logic [7:0]           r_s2_lit_data;
    logic                 r_s2_last;
    logic                 r_fwd_hit;
    logic [7:0]           r_fwd_data;
    logic [WIN_AW-1:0]    r_wp;

    logic [7:0]           r_ofifo_data [OFIFO_DEPTH];
    logic                 r_ofifo_last [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]  r_owp;
    logic [OFIFO_AW-1:0]  r_orp;
    logic [OFIFO_CW-1:0]  r_ocnt;

    logic                 space;
    logic                 issue;
    logic                 load;
    logic                 last;
    logic                 opop;
    logic [7:0]           rdata;
    logic [7:0]           s2_data;
    logic                 we;
    logic [WIN_AW-1:0]    waddr;
    logic [7:0]           wdata;

    lzd_ram #(
        .Width (8),
        .Depth (WINDOW_SIZE)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    assign space   = (r_ocnt + OFIFO_CW'(r_s2_valid)) < OFIFO_CW'(OFIFO_DEPTH);
    assign issue   = r_busy && space && !r_clr_busy;
    assign load    = !r_busy && !i_cmd_empty && !r_clr_busy;
    assign last    = r_lit || (r_left == '0);
    assign s2_data = r_s2_lit ? r_s2_lit_data : (r_fwd_hit ? r_fwd_data : rdata);

    assign we    = r_clr_busy || r_s2_valid;
    assign waddr = r_clr_busy ? r_clr_addr : r_wp;
    assign wdata = r_clr_busy ? FILL_BYTE : s2_data;

    assign o_cmd_pop     = load;
    assign o_clearing    = r_clr_busy;
    assign o_empty       = (r_ocnt == '0);
    assign o_out_byte    = r_ofifo_data[r_orp];
    assign o_last_of_run = r_ofifo_last[r_orp];
    assign opop          = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_ofifo_data[r_owp] <= s2_data;
            r_ofifo_last[r_owp] <= r_s2_last;
        end
        r_s2_lit      <= r_lit;
        r_s2_lit_data <= r_addr[7:0];
        r_s2_last     <= last;
        r_fwd_data    <= s2_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_busy     <= 1'b0;
            r_lit      <= 1'b0;
            r_addr     <= '0;
            r_left     <= '0;
            r_s2_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_wp       <= START_POS;
            r_owp      <= '0;
            r_orp      <= '0;
            r_ocnt     <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + WIN_AW'(1);
                if (r_clr_addr == WIN_AW'(WINDOW_SIZE - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            if (load) begin
                r_busy <= 1'b1;
                r_lit  <= i_cmd.lit;
                r_addr <= i_cmd.addr;
                r_left <= i_cmd.lit ? '0
                                    : LEFT_W'(i_cmd.len) + LEFT_W'(MIN_LEN - 1);
            end else if (issue) begin
                if (last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_addr <= r_addr + WIN_AW'(1);
                    r_left <= r_left - LEFT_W'(1);
                end
            end

            r_s2_valid <= issue;
            r_fwd_hit  <= issue && !r_lit && r_s2_valid && (r_addr == r_wp);

            if (r_s2_valid) begin
                r_wp  <= r_wp + WIN_AW'(1);
                r_owp <= r_owp + OFIFO_AW'(1);
            end
            if (opop) begin
                r_orp <= r_orp + OFIFO_AW'(1);
            end
            r_ocnt <= r_ocnt + OFIFO_CW'(r_s2_valid) - OFIFO_CW'(opop);
        end
    end

endmodule
`default_nettype wire

### design/lzss_decoder_4k_window_top.sv
// Top level of the LZSS decoder with a 4096-byte window.
//
// Input queue side: drive push with one compressed byte on i_in_byte; the byte
// transfers at a rising edge with push high and full low. Output queue side:
// o_out_byte and o_last_of_run show the oldest decoded byte while empty is low;
// it transfers at a rising edge with pop high and empty low. o_last_of_run marks
// the final byte that one input byte causes.
// A flag byte or a first reference byte yields nothing.
// A literal yields one byte, which passes through the command queue, the copy
// engine and its output stage into the output queue. A reference yields its 3
// to 18 bytes at one byte per cycle while the output queue has room; the copy
// engine loads each command in a step of its own and takes no new command until
// it has issued the last byte of the current one.
// Byte order and overlapping copies follow the window write order exactly.
// After reset a clearing pass fills all 4096 window bytes with spaces;
// full stays high during that pass. Reset also restarts the stream parser.
// When the receiver stalls, the four-entry output queue fills, the copy engine
// holds, the two-entry command queue fills and full rises; nothing is dropped.
`default_nettype none
module lzss_decoder_4k_window_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    input  wire logic [7:0] i_in_byte,
    output logic            full,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run
);
    import lzd_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic front_push;
    logic q_full;
    logic q_empty;
    logic cmd_pop;
    logic clearing;

    assign full = q_full || clearing;

    lzd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_byte     (i_in_byte),
        .i_hold     (full),
        .o_cmd_push (front_push),
        .o_cmd      (front_cmd)
    );

    lzd_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (cmd_pop),
        .o_cmd   (queue_cmd),
        .o_empty (q_empty)
    );

    lzd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (queue_cmd),
        .i_cmd_empty   (q_empty),
        .o_cmd_pop     (cmd_pop),
        .o_clearing    (clearing),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_empty       (empty),
        .i_pop         (pop)
    );

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> !q_empty)
        else $error("command taken from an empty queue");

    a_no_cmd_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !cmd_pop && !front_push)
        else $error("command traffic during the clearing pass");

    a_no_output_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> empty)
        else $error("decoded byte present during the clearing pass");

endmodule
`default_nettype wire
